// ----- src/lfu_pkg.sv -----
`timescale 1ns / 1ps

package lfu_pkg;

  // Field widths that travel down the cell chain. They are sized for the
  // largest store the block supports. Narrower builds zero-extend into them.
  localparam int unsigned DATA_W = 32;
  localparam int unsigned IDX_W  = 8;   // slot index and recency rank, up to 256 slots
  localparam int unsigned CNT_W  = 32;  // use count, up to 32 bits
  localparam int unsigned OCC_W  = 9;   // occupancy, up to 256

  typedef enum logic [1:0] {
    UPD_NONE = 2'd0,
    UPD_BUMP = 2'd1,
    UPD_FILL = 2'd2
  } upd_op_e;

  // Scan packet, carried from one cell to the next, one cell per cycle
  typedef struct packed {
    logic              active;
    logic [DATA_W-1:0] key;
    logic              hit;
    logic [IDX_W-1:0]  hit_idx;
    logic [IDX_W-1:0]  hit_rank;
    logic [DATA_W-1:0] hit_value;
    logic              vic_found;
    logic [IDX_W-1:0]  vic_idx;
    logic [IDX_W-1:0]  vic_rank;
    logic [CNT_W-1:0]  vic_count;
    logic [DATA_W-1:0] vic_key;
    logic              free_found;
    logic [IDX_W-1:0]  free_idx;
    logic [OCC_W-1:0]  occ;
  } pkt_t;

  // Update command, broadcast to every cell for one cycle
  typedef struct packed {
    upd_op_e           op;
    logic [IDX_W-1:0]  idx;
    logic [IDX_W-1:0]  rank;
    logic              wr_value;
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] value;
    logic              evict;
    logic [IDX_W-1:0]  vic_idx;
    logic [IDX_W-1:0]  vic_rank;
  } upd_t;

endpackage

// ----- src/lfu_cell.sv -----
`timescale 1ns / 1ps

module lfu_cell #(
  parameter int IDX        = 0,
  parameter int RANK_W     = 4,
  parameter int COUNT_BITS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  lfu_pkg::pkt_t pkt_i,
  output lfu_pkg::pkt_t pkt_o,
  input  lfu_pkg::upd_t upd_i
);
  import lfu_pkg::*;

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(IDX);

  logic                  valid_q, valid_d;
  logic [DATA_W-1:0]     key_q, key_d;
  logic [DATA_W-1:0]     value_q, value_d;
  logic [COUNT_BITS-1:0] count_q, count_d;
  logic [RANK_W-1:0]     rank_q, rank_d;
  pkt_t                  pkt_q, pkt_d;

  logic [IDX_W-1:0] rank_ext;
  logic [CNT_W-1:0] count_ext;

  assign rank_ext  = IDX_W'(rank_q);
  assign count_ext = CNT_W'(count_q);

  // scan: fold this slot into the passing packet
  always_comb begin
    pkt_d = pkt_i;
    if (valid_q) begin
      pkt_d.occ = pkt_i.occ + 1'b1;
      if (key_q == pkt_i.key) begin
        pkt_d.hit       = 1'b1;
        pkt_d.hit_idx   = MyIdx;
        pkt_d.hit_rank  = rank_ext;
        pkt_d.hit_value = value_q;
      end
      if (!pkt_i.vic_found || (count_ext < pkt_i.vic_count) ||
          ((count_ext == pkt_i.vic_count) && (rank_ext > pkt_i.vic_rank))) begin
        pkt_d.vic_found = 1'b1;
        pkt_d.vic_idx   = MyIdx;
        pkt_d.vic_rank  = rank_ext;
        pkt_d.vic_count = count_ext;
        pkt_d.vic_key   = key_q;
      end
    end else if (!pkt_i.free_found) begin
      pkt_d.free_found = 1'b1;
      pkt_d.free_idx   = MyIdx;
    end
  end

  // update from the broadcast command
  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    value_d = value_q;
    count_d = count_q;
    rank_d  = rank_q;
    case (upd_i.op)
      UPD_BUMP: begin
        if (upd_i.idx == MyIdx) begin
          if (count_q != {COUNT_BITS{1'b1}}) begin
            count_d = count_q + 1'b1;
          end
          rank_d = '0;
          if (upd_i.wr_value) begin
            value_d = upd_i.value;
          end
        end else if (valid_q && (rank_ext < upd_i.rank)) begin
          rank_d = rank_q + 1'b1;
        end
      end
      UPD_FILL: begin
        if (upd_i.idx == MyIdx) begin
          valid_d = 1'b1;
          key_d   = upd_i.key;
          value_d = upd_i.value;
          count_d = COUNT_BITS'(1);
          rank_d  = '0;
        end else if (upd_i.evict && (upd_i.vic_idx == MyIdx)) begin
          valid_d = 1'b0;
        end else if (valid_q) begin
          // close the gap left by the victim, then age for the new entry
          if (!(upd_i.evict && (rank_ext > upd_i.vic_rank))) begin
            rank_d = rank_q + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pkt_q   <= '0;
    end else begin
      valid_q <= valid_d;
      pkt_q   <= pkt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    value_q <= value_d;
    count_q <= count_d;
    rank_q  <= rank_d;
  end

  assign pkt_o = pkt_q;

endmodule

// ----- src/lfu_cache_policy.sv -----
`timescale 1ns / 1ps

// Fully associative key-value store with least frequently used replacement,
// ties broken toward the least recently accessed entry. Each input
// transaction is a get or a put and yields exactly one result transaction
// (hit, read value, eviction flag and evicted key). Slots live in a row of
// ENTRIES cells; a scan packet enters the first cell and moves one cell per
// cycle, collecting the key match, the eviction candidate, the first free
// slot and the occupancy. Once it leaves the last cell, the controller
// latches it, decides, and broadcasts one update that every cell applies in
// the same cycle. Between one acceptance and the next, a transaction passes a
// launch register, the traversal of the ENTRIES-cell chain, a capture into the
// summary register and the commit. The commit waits while a previous result
// is still stalled on the output. Input stall is high from acceptance until
// commit. The capacity register (byte address 0) resets to 16; writes are
// expected only while the block is idle.
module lfu_cache_policy #(
  parameter int ENTRIES    = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        cmd_i,
  input  logic [31:0] key_i,
  input  logic [31:0] value_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        hit_o,
  output logic [31:0] read_value_o,
  output logic        evicted_o,
  output logic [31:0] evicted_key_o,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lfu_pkg::*;

  localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [4:0] CapReset = 5'd16;
  localparam logic [1:0] CapAddr  = 2'd0;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_DECIDE = 3'b100
  } state_e;

  state_e state_q, state_d;

  // configuration register
  logic [4:0] capacity_q;
  logic       cfg_wr;

  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  // single register: writes land here from any address, reads decode it
  assign prdata = (paddr == CapAddr) ? {27'b0, capacity_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CapReset;
    end else if (cfg_wr) begin
      capacity_q <= pwdata[4:0];
    end
  end

  // transaction registers
  logic        in_acc;
  logic        cmd_q;
  logic [31:0] key_q;
  logic [31:0] value_q;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q   <= cmd_i;
      key_q   <= key_i;
      value_q <= value_i;
    end
  end

  // launch packet feeding the first cell
  pkt_t start_q, start_d;

  always_comb begin
    start_d = '0;
    if (in_acc) begin
      start_d.active = 1'b1;
      start_d.key    = key_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
    end else begin
      start_q <= start_d;
    end
  end

  // cell chain
  pkt_t pkt_chain [ENTRIES+1];
  upd_t upd;

  assign pkt_chain[0] = start_q;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    lfu_cell #(
      .IDX        (g),
      .RANK_W     (RANK_W),
      .COUNT_BITS (COUNT_BITS)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .pkt_i  (pkt_chain[g]),
      .pkt_o  (pkt_chain[g+1]),
      .upd_i  (upd)
    );
  end

  // scan summary, held until the commit
  pkt_t sum_q;
  logic scan_done;

  assign scan_done = (state_q == S_SCAN) && pkt_chain[ENTRIES].active;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (scan_done) begin
      sum_q <= pkt_chain[ENTRIES];
    end
  end

  // decision
  logic [OCC_W-1:0] cap_lim;
  logic             fire;
  logic             evict;
  logic [IDX_W-1:0] ins_idx;
  upd_t             upd_calc;
  logic             res_ev;
  logic [31:0]      res_rd;
  logic [31:0]      res_ek;

  // capacity above the slot count acts as the slot count
  assign cap_lim = (32'(capacity_q) > ENTRIES) ? OCC_W'(ENTRIES) : OCC_W'(capacity_q);

  always_comb begin
    upd_calc          = '0;
    upd_calc.op       = UPD_NONE;
    upd_calc.key      = key_q;
    upd_calc.value    = value_q;
    upd_calc.vic_idx  = sum_q.vic_idx;
    upd_calc.vic_rank = sum_q.vic_rank;
    evict             = 1'b0;
    ins_idx           = sum_q.free_idx;
    res_rd            = 32'hFFFF_FFFF;
    if (!cmd_q) begin
      if (sum_q.hit) begin
        upd_calc.op   = UPD_BUMP;
        upd_calc.idx  = sum_q.hit_idx;
        upd_calc.rank = sum_q.hit_rank;
        res_rd        = sum_q.hit_value;
      end
    end else if (capacity_q != 5'd0) begin
      if (sum_q.hit) begin
        upd_calc.op       = UPD_BUMP;
        upd_calc.idx      = sum_q.hit_idx;
        upd_calc.rank     = sum_q.hit_rank;
        upd_calc.wr_value = 1'b1;
      end else begin
        evict = (sum_q.occ >= cap_lim) && sum_q.vic_found;
        // lowest empty slot, counting the victim's slot as empty
        if (evict && (!sum_q.free_found || (sum_q.vic_idx < sum_q.free_idx))) begin
          ins_idx = sum_q.vic_idx;
        end
        if (evict || sum_q.free_found) begin
          upd_calc.op    = UPD_FILL;
          upd_calc.idx   = ins_idx;
          upd_calc.evict = evict;
        end
      end
    end
    res_ev = evict;
    res_ek = evict ? sum_q.vic_key : 32'd0;
  end

  logic out_valid_q;
  logic hit_q;
  logic ev_q;
  logic [31:0] rd_q;
  logic [31:0] ek_q;

  assign fire = (state_q == S_DECIDE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    upd = upd_calc;
    if (!fire) begin
      upd.op = UPD_NONE;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      hit_q <= sum_q.hit;
      rd_q  <= res_rd;
      ev_q  <= res_ev;
      ek_q  <= res_ek;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign hit_o         = hit_q;
  assign read_value_o  = rd_q;
  assign evicted_o     = ev_q;
  assign evicted_key_o = ek_q;

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (in_acc) state_d = S_SCAN;
      S_SCAN:   if (scan_done) state_d = S_DECIDE;
      S_DECIDE: if (fire) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // the scan packet only leaves the chain while a transaction is scanning
  a_chain_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pkt_chain[ENTRIES].active |-> (state_q == S_SCAN))
    else $error("scan packet left the chain outside of a scan");

  // a put miss with nonzero capacity always finds a slot to fill
  a_slot_available: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_DECIDE) && cmd_q && !sum_q.hit && (capacity_q != 5'd0))
    |-> (sum_q.free_found || sum_q.vic_found))
    else $error("put miss found neither a free slot nor a victim");

  // an eviction only comes from a put miss
  a_evict_on_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> !(ev_q && hit_q) && (!ev_q || $past(cmd_q)))
    else $error("eviction reported on a hit or a get");

  // no update reaches the cells except at the commit
  a_update_at_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upd.op != UPD_NONE) |-> fire && (state_d == S_IDLE))
    else $error("cell update issued outside the commit cycle");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;

  localparam int          NSLOT      = 16;
  localparam logic [15:0] COUNT_SAT  = 16'hFFFF;
  localparam int          IDLE_PAUSE = NSLOT + 4;  // block latency plus margin
  localparam int          HOT_HITS   = 30;         // gets that lift one key's use count
  localparam logic [1:0]  CAP_ADDR   = 2'd0;
  localparam int          EXP_DEPTH  = 16;

  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } op_e;

  typedef struct packed {
    logic        hit;
    logic [31:0] read_value;
    logic        evicted;
    logic [31:0] evicted_key;
  } access_result_t;

  // clock, reset and block inputs, all known from time zero
  logic        clk      = 1'b0;
  logic        rst_n    = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_cmd   = 1'b0;
  logic [31:0] in_key   = '0;
  logic [31:0] in_value = '0;
  logic        out_stall = 1'b0;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [1:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;

  logic        in_stall;
  logic        out_valid;
  logic        hit;
  logic [31:0] read_value;
  logic        evicted;
  logic [31:0] evicted_key;
  logic [31:0] prdata;
  logic        pready;

  // when set, neither side idles
  logic        calm = 1'b0;
  int          errors = 0;

  // outstanding expectations, oldest first
  access_result_t exp_fifo [EXP_DEPTH];
  logic [3:0]     exp_wr    = '0;
  logic [3:0]     exp_rd    = '0;
  int             exp_count = 0;

  // shadow copy of the store
  logic        shadow_valid [NSLOT];
  logic [31:0] shadow_key   [NSLOT];
  logic [31:0] shadow_value [NSLOT];
  logic [15:0] shadow_count [NSLOT];
  logic [3:0]  shadow_rank  [NSLOT];
  logic [4:0]  shadow_cap;

  logic [31:0] key_pool [24];

  lfu_cache_policy dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .cmd_i         (in_cmd),
    .key_i         (in_key),
    .value_i       (in_value),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .hit_o         (hit),
    .read_value_o  (read_value),
    .evicted_o     (evicted),
    .evicted_key_o (evicted_key),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #100_000_000;
    $display("tb NOT OK");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (errors < 100) begin
      $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
    end
    errors++;
  endtask

  function automatic void exp_store(input access_result_t r);
    exp_fifo[exp_wr] = r;
    exp_wr++;
    exp_count++;
  endfunction

  function automatic access_result_t exp_take();
    access_result_t r;
    r = exp_fifo[exp_rd];
    exp_rd++;
    exp_count--;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Shadow store
  // ---------------------------------------------------------------------------

  // count bump (saturating) and move to most recent
  function automatic void touch_slot(input int s);
    logic [3:0] r;
    r = shadow_rank[s];
    if (shadow_count[s] != COUNT_SAT) shadow_count[s]++;
    for (int i = 0; i < NSLOT; i++) begin
      if (shadow_valid[i] && shadow_rank[i] < r) shadow_rank[i]++;
    end
    shadow_rank[s] = '0;
  endfunction

  function automatic access_result_t predict_access(input op_e c, input logic [31:0] k,
                                                    input logic [31:0] v);
    access_result_t res;
    int         hit_slot;
    int         victim;
    int         free_slot;
    int         occ;
    int         lim;
    logic [3:0] vr;
    res.hit         = 1'b0;
    res.read_value  = '1;
    res.evicted     = 1'b0;
    res.evicted_key = '0;
    hit_slot  = -1;
    victim    = -1;
    free_slot = -1;
    occ       = 0;
    for (int i = 0; i < NSLOT; i++) begin
      if (hit_slot < 0 && shadow_valid[i] && shadow_key[i] == k) hit_slot = i;
    end
    res.hit = (hit_slot >= 0);
    if (c == OP_GET) begin
      if (hit_slot >= 0) begin
        touch_slot(hit_slot);
        res.read_value = shadow_value[hit_slot];
      end
    end else if (shadow_cap != 0) begin
      if (hit_slot >= 0) begin
        shadow_value[hit_slot] = v;
        touch_slot(hit_slot);
      end else begin
        lim = (shadow_cap > NSLOT) ? NSLOT : int'(shadow_cap);
        for (int i = 0; i < NSLOT; i++) begin
          if (shadow_valid[i]) occ++;
        end
        // full at the configured capacity: drop lowest count, oldest on a tie
        if (occ >= lim) begin
          for (int i = 0; i < NSLOT; i++) begin
            if (shadow_valid[i] &&
                (victim < 0 || shadow_count[i] < shadow_count[victim] ||
                 (shadow_count[i] == shadow_count[victim] &&
                  shadow_rank[i] > shadow_rank[victim]))) begin
              victim = i;
            end
          end
          if (victim >= 0) begin
            vr = shadow_rank[victim];
            res.evicted     = 1'b1;
            res.evicted_key = shadow_key[victim];
            shadow_valid[victim] = 1'b0;
            for (int i = 0; i < NSLOT; i++) begin
              if (shadow_valid[i] && shadow_rank[i] > vr) shadow_rank[i]--;
            end
          end
        end
        for (int i = 0; i < NSLOT; i++) begin
          if (free_slot < 0 && !shadow_valid[i]) free_slot = i;
        end
        if (free_slot >= 0) begin
          for (int i = 0; i < NSLOT; i++) begin
            if (shadow_valid[i]) shadow_rank[i]++;
          end
          shadow_valid[free_slot] = 1'b1;
          shadow_key[free_slot]   = k;
          shadow_value[free_slot] = v;
          shadow_count[free_slot] = 16'd1;
          shadow_rank[free_slot]  = '0;
        end
      end
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // One input transaction. Valid is left high after acceptance; the next call
  // or wait_idle deals with it at the following falling edge, while the block
  // still holds stall high.
  task automatic send_item(input op_e c, input logic [31:0] k, input logic [31:0] v);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 24) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_cmd   <= c;
    in_key   <= k;
    in_value <= v;
    do @(posedge clk); while (in_stall);
    exp_store(predict_access(c, k, v));
  endtask

  // stop sending and let every outstanding result drain
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (exp_count != 0) @(negedge clk);
    repeat (IDLE_PAUSE) @(negedge clk);
  endtask

  // capacity write, then read back and compare
  task automatic set_capacity(input logic [4:0] cap);
    logic [31:0] rd;
    wait_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CAP_ADDR;
    pwdata  <= {27'd0, cap};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    shadow_cap = cap;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd !== {27'd0, shadow_cap}) report_mismatch("capacity readback", rd,
                                                    {27'd0, shadow_cap});
  endtask

  // receiver stalls at random
  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 24);
  end

  // each result transaction against the oldest expectation
  always @(posedge clk) begin : check_results
    access_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (exp_count == 0) begin
        report_mismatch("result with nothing outstanding", {31'd0, hit}, '0);
      end else begin
        want = exp_take();
        if (hit !== want.hit) report_mismatch("hit", {31'd0, hit}, {31'd0, want.hit});
        if (read_value !== want.read_value)
          report_mismatch("read_value", read_value, want.read_value);
        if (evicted !== want.evicted)
          report_mismatch("evicted", {31'd0, evicted}, {31'd0, want.evicted});
        if (evicted_key !== want.evicted_key)
          report_mismatch("evicted_key", evicted_key, want.evicted_key);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // empty-store miss, extreme keys and values, put hit overwrite, get miss
  task automatic test_basic_ops();
    send_item(OP_GET, 32'h0000_0000, 32'h0000_0000);
    send_item(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_item(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_item(OP_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
    send_item(OP_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
    send_item(OP_GET, 32'h8000_0000, 32'h0000_0000);
    send_item(OP_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_item(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    // stored -1 looks like a miss value, hit tells them apart
    send_item(OP_GET, 32'h0000_0000, 32'h0000_0000);
    send_item(OP_PUT, 32'h0000_0000, 32'h5A5A_A5A5);
    send_item(OP_GET, 32'h0000_0000, 32'h0000_0000);
    send_item(OP_GET, 32'h0000_0001, 32'hFFFF_FFFF);
    send_item(OP_GET, 32'hFFFF_FFFF, 32'h1234_5678);
  endtask

  // zero capacity, capacity under occupancy, capacity above the slot count
  task automatic test_capacity_limits();
    set_capacity(5'd0);
    send_item(OP_PUT, 32'h0001_2345, 32'h1111_1111);
    send_item(OP_PUT, 32'h7FFF_FFFF, 32'h2222_2222);
    send_item(OP_GET, 32'h7FFF_FFFF, 32'h0000_0000);
    send_item(OP_GET, 32'h0001_2345, 32'h0000_0000);
    // four entries live, limit three: each miss evicts one and inserts
    set_capacity(5'd3);
    send_item(OP_PUT, 32'h0000_1111, 32'hAAAA_AAAA);
    send_item(OP_PUT, 32'h0000_2222, 32'h5555_5555);
    set_capacity(5'd31);
    send_item(OP_PUT, 32'h0000_3333, 32'hDEAD_BEEF);
    set_capacity(5'd17);
    send_item(OP_PUT, 32'h0000_4444, 32'h0BAD_F00D);
    set_capacity(5'd1);
    send_item(OP_PUT, 32'h0000_5555, 32'hCAFE_0001);
  endtask

  // Random gets and puts over a small key pool so that hits, overwrites and
  // evictions are common; a few fully random keys for bit coverage. Capacity
  // grows first so the partly filled regime is seen before the store fills.
  task automatic test_random_traffic();
    logic [4:0]  caps [8];
    int          n;
    op_e         c;
    logic [31:0] k;
    caps = '{5'd6, 5'd9, 5'd12, 5'd1, 5'd0, 5'd31, 5'd17, 5'd16};
    foreach (key_pool[i]) key_pool[i] = $urandom;
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7FFF_FFFF;
    for (int p = 0; p < 8; p++) begin
      set_capacity(caps[p]);
      calm = (p == 5);
      n = $urandom_range(95, 120);
      for (int j = 0; j < n; j++) begin
        c = ($urandom_range(99) < 45) ? OP_PUT : OP_GET;
        k = ($urandom_range(99) < 85) ? key_pool[$urandom_range(23)] : $urandom;
        send_item(c, k, $urandom);
      end
      calm = 1'b0;
    end
  endtask

  // One key read many times outlives a stream of fresh keys: its high use
  // count keeps it from being picked as the victim.
  task automatic test_hot_key();
    logic [31:0] hot;
    hot = 32'hC0FF_EE00;
    set_capacity(5'd16);
    calm = 1'b1;
    send_item(OP_PUT, hot, 32'h0000_0042);
    for (int i = 0; i < HOT_HITS; i++) send_item(OP_GET, hot, '0);
    for (int i = 0; i < 20; i++) send_item(OP_PUT, 32'h5A00_0000 + i, $urandom);
    send_item(OP_GET, hot, '0);
    calm = 1'b0;
  endtask

  initial begin
    foreach (shadow_valid[i]) begin
      shadow_valid[i] = 1'b0;
      shadow_key[i]   = '0;
      shadow_value[i] = '0;
      shadow_count[i] = '0;
      shadow_rank[i]  = '0;
    end
    shadow_cap = 5'd16;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_basic_ops();
    test_capacity_limits();
    test_random_traffic();
    test_hot_key();

    wait_idle();
    if (errors == 0 && exp_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
